/* rtl/palette_color_resolver_defines.svh */
// Assertion macros shared by the palette color resolver RTL.
`ifndef PALETTE_COLOR_RESOLVER_DEFINES_SVH
`define PALETTE_COLOR_RESOLVER_DEFINES_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define PCR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define PCR_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define PCR_ASSERT(lbl, clk, rstn, prop, msg)
`define PCR_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* rtl/pcr_pkg.sv */
// Shared constants and types of the palette color resolver.
package pcr_pkg;

  localparam int PALETTE_SIZE = 256;
  localparam int SLOT_W       = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int COUNT_W      = $clog2(PALETTE_SIZE + 1);
  localparam int CH_W         = 8;
  localparam int COLOR_W      = 3 * CH_W;
  localparam int SQ_W         = 2 * CH_W;
  localparam int DIST_W       = SQ_W + 2;
  localparam int NUM_W        = 9;

  localparam logic [NUM_W-1:0] COLOR_BASE = 9'd32;

  typedef logic [SLOT_W-1:0] slot_t;

  // Stored color, red in the top byte.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // Tag that follows one memory read through the distance pipeline.
  typedef struct packed {
    logic  vld;
    slot_t slot;
  } probe_t;

endpackage

/* rtl/palette_color_resolver.sv */
// Top level of the palette color resolver: palette memory, scan control, result register.
//
//   Channel  Direction  Beat contents (lowest bits first)
//   in_*     input      tdata: red_in[7:0], green_in[15:8], blue_in[23:16]
//   out_*    output     tdata: color_number[8:0], zero fill; tuser: is_new
//
// One request is worked on at a time. After a beat is accepted, the palette
// memory is read one entry per cycle over its single read port. With N slots in
// use the scan issues N reads; the control then drains the read register and the
// distance pipeline and takes the last compare, and the decision step picks the
// result and writes a new entry if needed. An empty palette skips the scan and
// goes straight to the decision step. The control returns to idle after each
// result, and only there is the next request beat accepted.
// The result waits in an output register; the next request beat is accepted
// while it is still pending, and only the decision step waits for it to drain.
// Reset is synchronous and active low and empties the palette by clearing the
// entry count; memory contents are never cleared, as only occupied slots are read.
`include "palette_color_resolver_defines.svh"

module palette_color_resolver
  import pcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // color_number[8:0], zeros above
  output logic [0:0]  out_tuser   // is_new
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

  state_t             state_r;
  rgb_t               palette_mem [PALETTE_SIZE];
  rgb_t               rd_data_r;
  logic               rd_vld_r;
  slot_t              rd_slot_r;
  slot_t              issue_addr_r;
  logic [COUNT_W-1:0] count_r;
  rgb_t               req_r;
  logic               have_best_r;
  logic [DIST_W-1:0]  best_dist_r;
  slot_t              best_slot_r;
  logic               out_valid_r;
  logic [NUM_W-1:0]   out_num_r;
  logic               out_new_r;

  probe_t             probe_in;
  probe_t             probe_out;
  logic [DIST_W-1:0]  probe_dist;
  logic               pipe_busy;

  logic               rd_en;
  logic               scan_last;
  logic               out_free;
  logic               exact;
  logic               has_room;
  logic               fresh;
  slot_t              chosen;
  logic               decide_fire;
  logic               wr_en;

  assign in_tready = (state_r == S_IDLE);
  assign rd_en     = (state_r == S_SCAN);
  assign scan_last = (COUNT_W'(issue_addr_r) + COUNT_W'(1)) == count_r;
  assign out_free  = !out_valid_r || out_tready;

  // An exact match is a best distance of zero; the strict compare keeps the lowest slot.
  assign exact    = have_best_r && (best_dist_r == '0);
  assign has_room = count_r < COUNT_W'(PALETTE_SIZE);
  assign fresh    = !exact && has_room;
  assign chosen   = fresh ? count_r[SLOT_W-1:0] : best_slot_r;

  assign decide_fire = (state_r == S_DECIDE) && out_free;
  assign wr_en       = decide_fire && fresh;

  // Palette memory: one write port for appends, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      palette_mem[count_r[SLOT_W-1:0]] <= req_r;
    end
    if (rd_en) begin
      rd_data_r <= palette_mem[issue_addr_r];
    end
  end

  assign probe_in.vld  = rd_vld_r;
  assign probe_in.slot = rd_slot_r;

  pcr_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .entry    (rd_data_r),
    .req      (req_r),
    .tag_in   (probe_in),
    .dist_sum (probe_dist),
    .tag_out  (probe_out),
    .busy     (pipe_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      count_r     <= '0;
      have_best_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r  <= rd_en;
      rd_slot_r <= issue_addr_r;

      // A beat taken in the same cycle as a new decision is replaced, not cleared.
      if (out_valid_r && out_tready && !decide_fire) begin
        out_valid_r <= 1'b0;
      end

      // Keep the nearest entry seen so far; later slots win only when strictly closer.
      if (probe_out.vld && (!have_best_r || probe_dist < best_dist_r)) begin
        have_best_r <= 1'b1;
        best_dist_r <= probe_dist;
        best_slot_r <= probe_out.slot;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            req_r.red    <= in_tdata[7:0];
            req_r.green  <= in_tdata[15:8];
            req_r.blue   <= in_tdata[23:16];
            have_best_r  <= 1'b0;
            issue_addr_r <= '0;
            state_r      <= (count_r == '0) ? S_DECIDE : S_SCAN;
          end
        end
        S_SCAN: begin
          issue_addr_r <= issue_addr_r + SLOT_W'(1);
          if (scan_last) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_vld_r && !pipe_busy) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_num_r   <= NUM_W'(chosen) + COLOR_BASE;
            out_new_r   <= fresh;
            if (fresh) begin
              count_r <= count_r + COUNT_W'(1);
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 16'(out_num_r);
  assign out_tuser  = out_new_r;

  `PCR_NEVER(a_count_bound, clk, rst_n, count_r > COUNT_W'(PALETTE_SIZE), "count past size")
  `PCR_ASSERT(a_read_occupied, clk, rst_n, rd_en |-> (COUNT_W'(issue_addr_r) < count_r), "read of free slot")
  `PCR_ASSERT(a_decide_drained, clk, rst_n, (state_r == S_DECIDE) |-> (!rd_vld_r && !pipe_busy), "decide before drain")
  `PCR_ASSERT(a_append_counts, clk, rst_n, wr_en |=> (count_r == $past(count_r) + COUNT_W'(1)), "append lost")

endmodule

/* rtl/pcr_dist.sv */
// Two-stage squared RGB distance pipeline between a stored entry and the request.
module pcr_dist
  import pcr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  rgb_t              entry,
  input  rgb_t              req,
  input  probe_t            tag_in,
  output logic [DIST_W-1:0] dist_sum,
  output probe_t            tag_out,
  output logic              busy
);

  logic [CH_W-1:0] dr, dg, db;
  logic [SQ_W-1:0] sq_r_r, sq_g_r, sq_b_r;
  probe_t          tag_sq_r;
  logic [DIST_W-1:0] dist_r;
  probe_t          tag_out_r;

  assign dr = (entry.red   > req.red)   ? entry.red   - req.red   : req.red   - entry.red;
  assign dg = (entry.green > req.green) ? entry.green - req.green : req.green - entry.green;
  assign db = (entry.blue  > req.blue)  ? entry.blue  - req.blue  : req.blue  - entry.blue;

  always_ff @(posedge clk) begin
    sq_r_r <= SQ_W'(dr) * SQ_W'(dr);
    sq_g_r <= SQ_W'(dg) * SQ_W'(dg);
    sq_b_r <= SQ_W'(db) * SQ_W'(db);
    dist_r <= DIST_W'(sq_r_r) + DIST_W'(sq_g_r) + DIST_W'(sq_b_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_sq_r.vld  <= 1'b0;
      tag_out_r.vld <= 1'b0;
    end else begin
      tag_sq_r  <= tag_in;
      tag_out_r <= tag_sq_r;
    end
  end

  assign dist_sum = dist_r;
  assign tag_out  = tag_out_r;
  assign busy     = tag_sq_r.vld | tag_out_r.vld;

endmodule
